[design/rmop_pkg.sv]
// Shared constants, types and state encoding for the running median block.
package rmop_pkg;

  localparam int CAPACITY = 1024;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  // Two-level readout tree: low index bits pick inside a group, high bits pick the group.
  localparam int GRP_W    = IDX_W / 2;
  localparam int HI_W     = IDX_W - GRP_W;
  localparam int GRP_N    = 1 << GRP_W;
  localparam int NGRP     = (CAPACITY + GRP_N - 1) / GRP_N;
  localparam int PAD_N    = NGRP * GRP_N;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [COUNT_W-1:0]       count_t;

  // Value handed from one cell to the next, with its "greater than sample" flag.
  typedef struct packed {
    word_t val;
    logic  gt;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SEL,
    ST_OUT
  } state_t;

endpackage

[design/rmop_if.sv]
// Valid/ready channel interfaces for samples in and medians out.
interface rmop_in_if import rmop_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t sample;
  logic  start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface rmop_out_if import rmop_pkg::*; ();
  logic   valid;
  logic   ready;
  word_t  median;
  count_t count;
  logic   overflow;

  modport source (output valid, output median, output count, output overflow, input ready);
  modport sink   (input valid, input median, input count, input overflow, output ready);
endinterface

[design/rmop_cell.sv]
// One slot of the sorted insertion chain.
module rmop_cell import rmop_pkg::*; (
  input  logic       clk,
  input  logic       ins,
  input  logic       vld,
  input  word_t      smp,
  input  cell_link_t prev,
  output cell_link_t link
);

  word_t val;
  logic  gt;

  // Held value is larger than the new sample: it moves up one slot.
  assign gt   = vld && (val > smp);
  assign link = '{val: val, gt: gt};

  // Shift in the lower neighbor if it also moves, else take the sample.
  always_ff @(posedge clk) begin
    if (ins && (gt || !vld)) begin
      val <= prev.gt ? prev.val : smp;
    end
  end

endmodule

[design/rmop_mid_sel.sv]
// Two-stage select of one chain slot: group pick registered, then final pick.
module rmop_mid_sel import rmop_pkg::*; (
  input  logic  clk,
  input  logic  load,
  input  word_t store [CAPACITY],
  input  idx_t  idx,
  output word_t sel
);

  word_t pad [PAD_N];
  word_t grp_q [NGRP];
  logic [GRP_W-1:0] lo;
  logic [HI_W-1:0]  hi;

  assign lo = idx[GRP_W-1:0];
  assign hi = idx[IDX_W-1:GRP_W];

  always_comb begin
    for (int i = 0; i < PAD_N; i++) begin
      pad[i] = (i < CAPACITY) ? store[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= pad[{HI_W'(g), lo}];
      end
    end
  end

  assign sel = grp_q[hi];

endmodule

[design/running_median_odd_prefix_core.sv]
// Running median of a signed sample stream, built on a sorted insertion chain.
// Order: a sample passes the insert, select and output states before its result is valid (later if out stalls).
// Samples: a new sample is taken only in the idle state, once the last one has been inserted
//   and, when it yields a median, read out through the two-stage median readout tree and loaded to out.
// Reset (rst, synchronous): held count and drop flag cleared, out empty, in ready.
//   Slot contents are not cleared; only slots below the held count are ever read.
module running_median_odd_prefix_core import rmop_pkg::*; (
  input logic       clk,
  input logic       rst,
  rmop_in_if.sink   in_ch,
  rmop_out_if.source out_ch
);

  state_t state, state_next;

  // Control and bookkeeping.
  cnt_t  held_count;
  logic  dropped;
  word_t smp_q;
  logic  full;
  logic  ins_en;
  logic  sel_ld;
  logic  out_ld;
  logic  in_xfer;
  logic  emit;

  // Readout bookkeeping for the pending result.
  idx_t  mid_idx;
  cnt_t  res_count;
  logic  res_ovf;

  // Output register.
  logic  out_vld;
  word_t out_med;
  cnt_t  out_cnt;
  logic  out_ovf;

  // Chain.
  logic [CAPACITY-1:0] cell_vld;
  cell_link_t          link [CAPACITY];
  cell_link_t          seed;
  word_t               store [CAPACITY];
  word_t               mid_val;

  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign full    = (held_count == cnt_t'(CAPACITY));
  // New count is odd when the old one is even; a full store always reports the drop.
  assign emit    = full || !held_count[0];
  assign seed    = '{val: smp_q, gt: 1'b0};

  // Slot i holds a live value when it sits below the held count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    assign cell_vld[i] = (CNT_W'(i) < held_count);
    assign store[i]    = link[i].val;
    if (i == 0) begin : g_first
      rmop_cell u_cell (
        .clk  (clk),
        .ins  (ins_en),
        .vld  (cell_vld[i]),
        .smp  (smp_q),
        .prev (seed),
        .link (link[i])
      );
    end else begin : g_rest
      rmop_cell u_cell (
        .clk  (clk),
        .ins  (ins_en),
        .vld  (cell_vld[i]),
        .smp  (smp_q),
        .prev (link[i-1]),
        .link (link[i])
      );
    end
  end

  rmop_mid_sel u_mid_sel (
    .clk   (clk),
    .load  (sel_ld),
    .store (store),
    .idx   (mid_idx),
    .sel   (mid_val)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_xfer) state_next = ST_INSERT;
      ST_INSERT: state_next = emit ? ST_SEL : ST_IDLE;
      ST_SEL:    state_next = ST_OUT;
      ST_OUT:    if (out_ld) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    ins_en      = 1'b0;
    sel_ld      = 1'b0;
    out_ld      = 1'b0;
    case (state)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_INSERT: ins_en = !full;
      ST_SEL:    sel_ld = 1'b1;
      ST_OUT:    out_ld = !out_vld || out_ch.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Held count and drop flag; a start request empties the store at the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      dropped    <= 1'b0;
    end else if (in_xfer && in_ch.start_req) begin
      held_count <= '0;
      dropped    <= 1'b0;
    end else if (state == ST_INSERT) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        held_count <= held_count + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp_q <= in_ch.sample;
    end
  end

  // Median slot: lower middle of the full store, else middle after the insert.
  always_ff @(posedge clk) begin
    if (state == ST_INSERT) begin
      if (full) begin
        mid_idx   <= IDX_W'((held_count - cnt_t'(1)) >> 1);
        res_count <= held_count;
        res_ovf   <= 1'b1;
      end else begin
        mid_idx   <= IDX_W'(held_count >> 1);
        res_count <= held_count + cnt_t'(1);
        res_ovf   <= dropped;
      end
    end
  end

  // Output register; a new result loads only once the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_ld) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_med <= mid_val;
      out_cnt <= res_count;
      out_ovf <= res_ovf;
    end
  end

  // Count field carries the low bits of the held count.
  assign cnt_ext = {{COUNT_W{1'b0}}, out_cnt};

  assign out_ch.valid    = out_vld;
  assign out_ch.median   = out_med;
  assign out_ch.count    = cnt_ext[COUNT_W-1:0];
  assign out_ch.overflow = out_ovf;

endmodule
